// File: rtl/core/dtfx_pkg.sv
// ----------------------------------------------------------------------------
// dtfx_pkg
// Shared types, character codes and elaboration helpers for the decimal text
// to fixed point converter.
// ----------------------------------------------------------------------------
`default_nettype none

package dtfx_pkg;

  // Default configuration of the converter.
  localparam int FRAC_BITS_DEF       = 24;
  localparam int MAX_FRAC_DIGITS_DEF = 9;

  // Width of the fixed point value in a result.
  localparam int VALUE_W = 32;

  // Character codes used by the grammar.
  localparam logic [7:0] CH_ZERO     = 8'd48;
  localparam logic [7:0] CH_NINE     = 8'd57;
  localparam logic [7:0] CH_PLUS     = 8'd43;
  localparam logic [7:0] CH_MINUS    = 8'd45;
  localparam logic [7:0] CH_POINT    = 8'd46;
  localparam logic [7:0] CH_SPACE    = 8'd32;
  localparam logic [7:0] CH_CTRL_LO  = 8'd8;
  localparam logic [7:0] CH_CTRL_HI  = 8'd13;

  // One character of the input string.
  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } char_t;

  // One converted number.
  typedef struct packed {
    logic                      is_valid;
    logic signed [VALUE_W-1:0] fixed_value;
    logic                      overflowed;
  } result_t;

  // Status of a finished string, handed from the parser to the packer.
  typedef struct packed {
    logic negative;
    logic saturated;
    logic valid;
  } dtfx_flags_t;

  // Power of ten, used only to build constants at elaboration.
  function automatic logic [63:0] pow10(input int n);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < n; i++) begin
      p = p * 64'd10;
    end
    return p;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/dtfx_parse.sv
// ----------------------------------------------------------------------------
// dtfx_parse
// Character parser: phase tracking, integer accumulation with clamp, and an
// exact running binary fraction kept as quotient and remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module dtfx_parse #(
  parameter int FRAC_BITS       = dtfx_pkg::FRAC_BITS_DEF,
  parameter int MAX_FRAC_DIGITS = dtfx_pkg::MAX_FRAC_DIGITS_DEF,
  localparam int INT_W          = (FRAC_BITS < 31) ? (32 - FRAC_BITS) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  take,
  input  dtfx_pkg::char_t       char_in,
  output dtfx_pkg::dtfx_flags_t flags_final,
  output logic [INT_W-1:0]      int_final,
  output logic [FRAC_BITS-1:0]  frac_final
);
  import dtfx_pkg::*;

  localparam int          CNT_W   = $clog2(MAX_FRAC_DIGITS + 1);
  localparam logic [63:0] DEN     = pow10(MAX_FRAC_DIGITS);
  localparam int          REM_W   = $clog2(DEN);
  localparam int          SUM_W   = REM_W + 4;
  localparam int          QSUM_W  = FRAC_BITS + 4;
  localparam int          ISUM_W  = INT_W + 4;
  localparam logic [63:0] CLAMP64 = (FRAC_BITS < 31) ? (64'd1 << (31 - FRAC_BITS)) : 64'd1;
  localparam logic [INT_W-1:0] INT_CLAMP = CLAMP64[INT_W-1:0];

  typedef enum logic [3:0] {
    PH_LEAD  = 4'b0001,
    PH_INT   = 4'b0010,
    PH_FRAC  = 4'b0100,
    PH_TRAIL = 4'b1000
  } phase_t;

  // Parse state.
  phase_t               phase;
  logic [1:0]           dot_tally;
  logic                 negative;
  logic [INT_W-1:0]     int_acc;
  logic [FRAC_BITS-1:0] frac_quot;
  logic [REM_W-1:0]     frac_rem;
  logic [CNT_W-1:0]     frac_count;
  logic                 first_point;
  logic                 started;
  logic                 saturated;
  logic                 invalid;

  phase_t               phase_next;
  logic [1:0]           dot_tally_next;
  logic                 negative_next;
  logic [INT_W-1:0]     int_acc_next;
  logic [FRAC_BITS-1:0] frac_quot_next;
  logic [REM_W-1:0]     frac_rem_next;
  logic [CNT_W-1:0]     frac_count_next;
  logic                 first_point_next;
  logic                 saturated_next;
  logic                 invalid_next;

  // Weight of the k-th fraction digit: 2^FRAC_BITS / 10^(k+1), split into an
  // integer quotient and a remainder scaled to the common denominator DEN.
  logic [FRAC_BITS-1:0] quot_tab [MAX_FRAC_DIGITS];
  logic [REM_W-1:0]     rem_tab  [MAX_FRAC_DIGITS];
  logic [SUM_W-1:0]     den_mult [10];

  for (genvar k = 0; k < MAX_FRAC_DIGITS; k++) begin : g_weight
    localparam logic [63:0] QK = (64'd1 << FRAC_BITS) / pow10(k + 1);
    localparam logic [63:0] RK =
      ((64'd1 << FRAC_BITS) % pow10(k + 1)) * pow10(MAX_FRAC_DIGITS - 1 - k);
    assign quot_tab[k] = QK[FRAC_BITS-1:0];
    assign rem_tab[k]  = RK[REM_W-1:0];
  end

  for (genvar j = 0; j < 10; j++) begin : g_den
    localparam logic [63:0] MJ = DEN * 64'(j);
    assign den_mult[j] = MJ[SUM_W-1:0];
  end

  // Character classes.
  logic [3:0] digit;
  logic       is_space;
  logic       is_digit;
  logic       is_point;
  logic       is_sign;

  assign digit    = char_in.char_code[3:0];
  assign is_space = ((char_in.char_code >= CH_CTRL_LO) && (char_in.char_code <= CH_CTRL_HI)) ||
                    (char_in.char_code == CH_SPACE);
  assign is_digit = (char_in.char_code >= CH_ZERO) && (char_in.char_code <= CH_NINE);
  assign is_point = (char_in.char_code == CH_POINT);
  assign is_sign  = (char_in.char_code == CH_PLUS) || (char_in.char_code == CH_MINUS);

  // Integer digit: multiply by ten, add, clamp just above the range.
  logic [ISUM_W-1:0] int_sum;
  logic              int_over;
  logic [INT_W-1:0]  int_add;

  assign int_sum  = ISUM_W'({int_acc, 3'b000}) + ISUM_W'({int_acc, 1'b0}) + ISUM_W'(digit);
  assign int_over = int_sum > ISUM_W'(INT_CLAMP);
  assign int_add  = int_over ? INT_CLAMP : int_sum[INT_W-1:0];

  // Fraction digit: add the digit weight and renormalize the remainder.
  logic                 frac_room;
  logic [FRAC_BITS-1:0] sel_quot;
  logic [REM_W-1:0]     sel_rem;
  logic [SUM_W-1:0]     rem_sum;
  logic [3:0]           rem_carry;
  logic [SUM_W-1:0]     rem_adj;
  logic [QSUM_W-1:0]    quot_sum;

  assign frac_room = frac_count < CNT_W'(MAX_FRAC_DIGITS);

  always_comb begin
    sel_quot = '0;
    sel_rem  = '0;
    for (int k = 0; k < MAX_FRAC_DIGITS; k++) begin
      if (frac_count == CNT_W'(k)) begin
        sel_quot = quot_tab[k];
        sel_rem  = rem_tab[k];
      end
    end
  end

  assign rem_sum = SUM_W'(frac_rem) + SUM_W'(sel_rem) * SUM_W'(digit);

  // The sum stays below ten times the denominator, so the carry is one digit.
  always_comb begin
    rem_carry = 4'd0;
    for (int j = 1; j < 10; j++) begin
      if (rem_sum >= den_mult[j]) begin
        rem_carry = 4'(j);
      end
    end
  end

  assign rem_adj  = rem_sum - den_mult[rem_carry];
  assign quot_sum = QSUM_W'(frac_quot) + QSUM_W'(sel_quot) * QSUM_W'(digit) +
                    QSUM_W'(rem_carry);

  // Next-state logic for one character.
  always_comb begin
    phase_next       = phase;
    dot_tally_next   = dot_tally;
    negative_next    = negative;
    int_acc_next     = int_acc;
    frac_quot_next   = frac_quot;
    frac_rem_next    = frac_rem;
    frac_count_next  = frac_count;
    first_point_next = first_point;
    saturated_next   = saturated;
    invalid_next     = invalid;

    if (is_point) begin
      if (dot_tally != 2'd2) begin
        dot_tally_next = dot_tally + 2'd1;
      end
      if (!started) begin
        first_point_next = 1'b1;
      end
    end

    unique case (phase)
      PH_LEAD: begin
        if (is_space) begin
          phase_next = PH_LEAD;
        end else if (is_sign) begin
          negative_next = (char_in.char_code == CH_MINUS);
          phase_next    = PH_INT;
        end else if (is_digit) begin
          int_acc_next   = int_add;
          saturated_next = saturated | int_over;
          phase_next     = PH_INT;
        end else if (is_point) begin
          phase_next = PH_FRAC;
        end else begin
          invalid_next = 1'b1;
          phase_next   = PH_TRAIL;
        end
      end
      PH_INT: begin
        if (is_digit) begin
          int_acc_next   = int_add;
          saturated_next = saturated | int_over;
        end else if (is_point) begin
          phase_next = PH_FRAC;
        end else if (is_space) begin
          phase_next = PH_TRAIL;
        end else begin
          invalid_next = 1'b1;
          phase_next   = PH_TRAIL;
        end
      end
      PH_FRAC: begin
        if (is_digit) begin
          if (frac_room) begin
            frac_quot_next  = quot_sum[FRAC_BITS-1:0];
            frac_rem_next   = rem_adj[REM_W-1:0];
            frac_count_next = frac_count + CNT_W'(1);
          end
        end else if (is_space) begin
          phase_next = PH_TRAIL;
        end else begin
          invalid_next = 1'b1;
          phase_next   = PH_TRAIL;
        end
      end
      default: begin
        phase_next = PH_TRAIL;
        if (!is_space) begin
          invalid_next = 1'b1;
        end
      end
    endcase
  end

  // Values of the string as they stand after this character.
  assign flags_final.negative  = negative_next;
  assign flags_final.saturated = saturated_next;
  assign flags_final.valid     = !invalid_next && (dot_tally_next != 2'd2) &&
                                 !(first_point_next && !started);
  assign int_final             = int_acc_next;
  assign frac_final            = frac_quot_next;

  // State update; the last character of a string returns the parser to reset.
  always_ff @(posedge clk) begin
    if (rst || (take && char_in.last_char)) begin
      phase       <= PH_LEAD;
      dot_tally   <= 2'd0;
      negative    <= 1'b0;
      int_acc     <= '0;
      frac_quot   <= '0;
      frac_rem    <= '0;
      frac_count  <= '0;
      first_point <= 1'b0;
      started     <= 1'b0;
      saturated   <= 1'b0;
      invalid     <= 1'b0;
    end else if (take) begin
      phase       <= phase_next;
      dot_tally   <= dot_tally_next;
      negative    <= negative_next;
      int_acc     <= int_acc_next;
      frac_quot   <= frac_quot_next;
      frac_rem    <= frac_rem_next;
      frac_count  <= frac_count_next;
      first_point <= first_point_next;
      started     <= 1'b1;
      saturated   <= saturated_next;
      invalid     <= invalid_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/dtfx_pack.sv
// ----------------------------------------------------------------------------
// dtfx_pack
// Result formatter: joins integer and fraction, saturates to the 32-bit range
// and applies the sign.
// ----------------------------------------------------------------------------
`default_nettype none

module dtfx_pack #(
  parameter int FRAC_BITS = dtfx_pkg::FRAC_BITS_DEF,
  localparam int INT_W    = (FRAC_BITS < 31) ? (32 - FRAC_BITS) : 1
) (
  input  dtfx_pkg::dtfx_flags_t flags,
  input  logic [INT_W-1:0]      int_val,
  input  logic [FRAC_BITS-1:0]  frac_val,
  output dtfx_pkg::result_t     result
);
  import dtfx_pkg::*;

  localparam int MAG_W = INT_W + FRAC_BITS + 1;
  localparam logic [MAG_W-1:0] POS_LIM = MAG_W'(33'h0_7FFF_FFFF);
  localparam logic [MAG_W-1:0] NEG_LIM = MAG_W'(33'h0_8000_0000);

  logic [MAG_W-1:0]   mag;
  logic [MAG_W-1:0]   limit;
  logic               ovf;
  logic [VALUE_W-1:0] mag_sat;

  // Magnitude is the integer shifted over the fraction field.
  assign mag   = MAG_W'({int_val, frac_val});
  assign limit = flags.negative ? NEG_LIM : POS_LIM;
  assign ovf   = flags.saturated || (mag > limit);

  assign mag_sat = ovf ? limit[VALUE_W-1:0] : mag[VALUE_W-1:0];

  assign result.is_valid    = flags.valid;
  assign result.fixed_value = flags.negative ? VALUE_W'(-mag_sat) : mag_sat;
  assign result.overflowed  = ovf;

endmodule

`default_nettype wire

// File: rtl/core/decimal_text_to_fixed_point.sv
// ----------------------------------------------------------------------------
// decimal_text_to_fixed_point
// Streams a decimal number one character at a time and returns its value in
// signed fixed point with a validity flag and an overflow flag.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Payload    Transaction
//   char     in         char_t     one character; last_char closes a string
//   result   out        result_t   one converted number per string
//
// One character is taken every cycle unless the input stalls; nothing iterates.
// The last character of a string passes the input register, then the string
// snapshot, then the result register, where its result turns valid and can
// be taken.
// Reset (rst, synchronous) empties the pipeline and returns the parser to the
// leading whitespace phase.
// A stalled result holds its value; characters keep flowing while one more
// finished string waits behind it, and the last character of the string after
// that waits in the input register and stalls further input.
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_text_to_fixed_point #(
  parameter int FRAC_BITS       = dtfx_pkg::FRAC_BITS_DEF,
  parameter int MAX_FRAC_DIGITS = dtfx_pkg::MAX_FRAC_DIGITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              char_valid,
  output logic              char_stall,
  input  dtfx_pkg::char_t   char_data,
  output logic              result_valid,
  input  logic              result_stall,
  output dtfx_pkg::result_t result_data
);
  import dtfx_pkg::*;

  localparam int INT_W = (FRAC_BITS < 31) ? (32 - FRAC_BITS) : 1;

  // Input register.
  char_t char_q;
  logic  char_q_valid;

  // Finished string waiting for formatting.
  dtfx_flags_t          snap_flags;
  logic [INT_W-1:0]     snap_int;
  logic [FRAC_BITS-1:0] snap_frac;
  logic                 snap_valid;

  dtfx_flags_t          flags_final;
  logic [INT_W-1:0]     int_final;
  logic [FRAC_BITS-1:0] frac_final;
  result_t              result_next;

  logic out_ready;
  logic snap_ready;
  logic take;
  logic char_take;

  // Flow control: only a last character needs room further down.
  assign out_ready  = !result_valid || !result_stall;
  assign snap_ready = !snap_valid || out_ready;
  assign take       = char_q_valid && (!char_q.last_char || snap_ready);
  assign char_stall = char_q_valid && !take;
  assign char_take  = char_valid && !char_stall;

  dtfx_parse #(
    .FRAC_BITS       (FRAC_BITS),
    .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
  ) u_parse (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .char_in     (char_q),
    .flags_final (flags_final),
    .int_final   (int_final),
    .frac_final  (frac_final)
  );

  dtfx_pack #(
    .FRAC_BITS (FRAC_BITS)
  ) u_pack (
    .flags    (snap_flags),
    .int_val  (snap_int),
    .frac_val (snap_frac),
    .result   (result_next)
  );

  // Input register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      char_q_valid <= 1'b0;
    end else if (char_take) begin
      char_q_valid <= 1'b1;
    end else if (take) begin
      char_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (char_take) begin
      char_q <= char_data;
    end
  end

  // Snapshot of a finished string.
  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (take && char_q.last_char) begin
      snap_valid <= 1'b1;
    end else if (out_ready) begin
      snap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && char_q.last_char) begin
      snap_flags <= flags_final;
      snap_int   <= int_final;
      snap_frac  <= frac_final;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (snap_valid && out_ready) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_valid && out_ready) begin
      result_data <= result_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/dtfx_check.sv
// ----------------------------------------------------------------------------
// dtfx_check
// Port-level checker for the decimal text to fixed point converter, bound to
// the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dtfx_check (
  input logic              clk,
  input logic              rst,
  input logic              char_valid,
  input logic              char_stall,
  input dtfx_pkg::char_t   char_data,
  input logic              result_valid,
  input logic              result_stall,
  input dtfx_pkg::result_t result_data
);
  import dtfx_pkg::*;

  logic       last_taken;
  logic       result_taken;
  logic [2:0] pending;

  assign last_taken   = char_valid && !char_stall && char_data.last_char;
  assign result_taken = result_valid && !result_stall;

  // Strings whose last character went in and whose result has not come out.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 3'd0;
    end else begin
      pending <= pending + 3'(last_taken) - 3'(result_taken);
    end
  end

  // A stalled result transaction holds its value.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result_data))
    else $error("result changed while stalled");

  // Every result belongs to a string whose last character was taken.
  a_result_owed: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> pending != 3'd0)
    else $error("result without a finished string");

  // The pipeline never holds more than three finished strings.
  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= 3'd3)
    else $error("too many strings in flight");

  // An overflowed value sits at one of the two range limits.
  a_ovf_limit: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_data.overflowed |->
      (result_data.fixed_value == 32'sh7FFF_FFFF) ||
      (result_data.fixed_value == 32'sh8000_0000))
    else $error("overflowed value not at a range limit");

  // Reset empties the result register.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind decimal_text_to_fixed_point dtfx_check u_dtfx_check (.*);

`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Feeds decimal number strings to the converter one character per transaction
// and checks every converted number against a software model of the parser.
// A directed set covers the corner cases, then random strings run under three
// idle patterns, a long receiver hold-off and a drain pause.
// ----------------------------------------------------------------------------

module tb_top;
  import dtfx_pkg::*;

  // Tracks the parse of the string in flight and keeps the numbers still owed.
  class number_tracker;
    localparam int FRAC_W = FRAC_BITS_DEF;
    localparam int FRAC_DIGITS_KEPT = MAX_FRAC_DIGITS_DEF;
    localparam longint unsigned INT_CLAMP = 64'd1 << (31 - FRAC_W);

    typedef enum logic [1:0] {LEAD_BLANKS, INT_DIGITS, FRAC_DIGITS, TRAIL_BLANKS} parse_phase_t;

    parse_phase_t    phase;
    int unsigned     dot_tally;
    bit              negative;
    longint unsigned int_part;
    longint unsigned frac_part;
    int unsigned     frac_count;
    bit              starts_with_point;
    bit              past_first;
    bit              int_clamped;
    bit              grammar_broken;
    result_t         pending_numbers[$];
    int unsigned     mismatch_count;

    function new();
      mismatch_count = 0;
      clear();
    endfunction

    function void clear();
      phase             = LEAD_BLANKS;
      dot_tally         = 0;
      negative          = 1'b0;
      int_part          = 0;
      frac_part         = 0;
      frac_count        = 0;
      starts_with_point = 1'b0;
      past_first        = 1'b0;
      int_clamped       = 1'b0;
      grammar_broken    = 1'b0;
    endfunction

    function int pending();
      return pending_numbers.size();
    endfunction

    function bit is_blank(logic [7:0] c);
      return (c >= CH_CTRL_LO && c <= CH_CTRL_HI) || c == CH_SPACE;
    endfunction

    function bit is_numeral(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function void add_int_digit(logic [7:0] c);
      longint unsigned v;
      v = int_part * 10 + (c - CH_ZERO);
      if (v > INT_CLAMP) begin
        v = INT_CLAMP;
        int_clamped = 1'b1;
      end
      int_part = v;
    endfunction

    function void break_grammar();
      grammar_broken = 1'b1;
      phase = TRAIL_BLANKS;
    endfunction

    task report_mismatch(string what, logic [31:0] got_v, logic [31:0] want_v);
      $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got_v, want_v);
      mismatch_count++;
    endtask

    // Advances the parse by one accepted character; the last one owes a number.
    function void take_char(char_t ch);
      logic [7:0]      c;
      longint unsigned den;
      longint unsigned rem;
      longint unsigned frac_bits;
      longint unsigned mag;
      longint unsigned limit;
      longint unsigned word;
      bit              ovf;
      result_t         want;
      c = ch.char_code;
      if (c == CH_POINT) begin
        if (dot_tally < 2) dot_tally++;
        if (!past_first) starts_with_point = 1'b1;
      end
      case (phase)
        LEAD_BLANKS: begin
          if (is_blank(c)) begin
          end else if (c == CH_PLUS || c == CH_MINUS) begin
            negative = (c == CH_MINUS);
            phase = INT_DIGITS;
          end else if (is_numeral(c)) begin
            add_int_digit(c);
            phase = INT_DIGITS;
          end else if (c == CH_POINT) begin
            phase = FRAC_DIGITS;
          end else begin
            break_grammar();
          end
        end
        INT_DIGITS: begin
          if (is_numeral(c)) add_int_digit(c);
          else if (c == CH_POINT) phase = FRAC_DIGITS;
          else if (is_blank(c)) phase = TRAIL_BLANKS;
          else break_grammar();
        end
        FRAC_DIGITS: begin
          if (is_numeral(c)) begin
            // Digits past the kept count are dropped.
            if (frac_count < FRAC_DIGITS_KEPT) begin
              frac_part = frac_part * 10 + (c - CH_ZERO);
              frac_count++;
            end
          end else if (is_blank(c)) begin
            phase = TRAIL_BLANKS;
          end else begin
            break_grammar();
          end
        end
        default: begin
          if (!is_blank(c)) grammar_broken = 1'b1;
        end
      endcase
      if (!ch.last_char) begin
        past_first = 1'b1;
        return;
      end

      // Fraction to binary by restoring division, truncated.
      den = 1;
      for (int i = 0; i < frac_count; i++) den = den * 10;
      rem = frac_part;
      frac_bits = 0;
      for (int i = 0; i < FRAC_W; i++) begin
        rem = rem << 1;
        frac_bits = frac_bits << 1;
        if (rem >= den) begin
          rem = rem - den;
          frac_bits = frac_bits | 1;
        end
      end

      // Saturate the magnitude to the signed 32-bit range, then apply the sign.
      mag = (int_part << FRAC_W) + frac_bits;
      limit = negative ? 64'h8000_0000 : 64'h7FFF_FFFF;
      ovf = int_clamped || mag > limit;
      if (ovf) mag = limit;
      word = negative ? (64'd0 - mag) : mag;

      want.is_valid = !grammar_broken && dot_tally < 2 &&
                      !(starts_with_point && !past_first);
      want.fixed_value = word[31:0];
      want.overflowed = ovf;
      pending_numbers.push_back(want);
      clear();
    endfunction

    // Compares one accepted result transaction with the oldest owed number.
    task check_number(result_t got);
      result_t want;
      if (pending_numbers.size() == 0) begin
        report_mismatch("unexpected result, value", got.fixed_value, 32'h0);
        return;
      end
      want = pending_numbers.pop_front();
      if (got.is_valid !== want.is_valid)
        report_mismatch("is_valid", got.is_valid, want.is_valid);
      if (got.fixed_value !== want.fixed_value)
        report_mismatch("fixed_value", got.fixed_value, want.fixed_value);
      if (got.overflowed !== want.overflowed)
        report_mismatch("overflowed", got.overflowed, want.overflowed);
    endtask
  endclass

  localparam int HALF_PERIOD     = 4;
  localparam int RESET_CYCLES    = 11;
  localparam int QUIET_LIMIT     = 2000;
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int DRAIN_CYCLES    = 10;
  localparam int TOTAL_CHARS     = 1550;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    char_valid = 1'b0;
  logic    char_stall;
  char_t   char_data = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result_data;

  number_tracker tracker = new();

  int unsigned send_idle_pct = 11;
  int unsigned recv_idle_pct = 46;
  int unsigned holds_asked = 0;
  int unsigned holds_done = 0;
  int unsigned quiet_cycles = 0;
  int unsigned chars_sent = 0;
  logic [7:0]  text_buf[$];

  decimal_text_to_fixed_point DUT (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .char_data    (char_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Observe both channels at the rising edge and watch for a hang.
  always @(posedge clk) begin
    if (!rst) begin
      if (char_valid && !char_stall) tracker.take_char(char_data);
      if (result_valid && !result_stall) tracker.check_number(result_data);
      if ((char_valid && !char_stall) || (result_valid && !result_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Result side: random stalls, or one long hold-off when asked.
  initial begin
    forever begin
      @(negedge clk);
      if (holds_done != holds_asked) begin
        result_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
        holds_done++;
      end else begin
        result_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Offers one character and returns at the falling edge after it is taken.
  task automatic send_char(char_t ch);
    while ($urandom_range(99) < send_idle_pct) begin
      char_valid <= 1'b0;
      @(negedge clk);
    end
    char_valid <= 1'b1;
    char_data  <= ch;
    @(posedge clk);
    while (char_stall) @(posedge clk);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_text();
    char_t ch;
    for (int i = 0; i < text_buf.size(); i++) begin
      ch.char_code = text_buf[i];
      ch.last_char = (i == text_buf.size() - 1);
      send_char(ch);
    end
  endtask

  task automatic send_word(string s);
    text_buf.delete();
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    send_text();
  endtask

  function automatic logic [7:0] blank_char();
    int unsigned k;
    k = $urandom_range(CH_CTRL_LO, CH_CTRL_HI + 1);
    return (k > CH_CTRL_HI) ? CH_SPACE : k[7:0];
  endfunction

  function automatic logic [7:0] digit_char();
    return CH_ZERO + 8'($urandom_range(9));
  endfunction

  // Builds a random string: mostly well-formed numbers, some corrupted, some noise.
  task automatic build_text();
    int unsigned kind;
    int unsigned n;
    int unsigned pick;
    int unsigned pos;
    logic [7:0]  junk;
    text_buf.delete();
    kind = $urandom_range(99);
    if (kind < 8) begin
      n = $urandom_range(1, 6);
      repeat (n) text_buf.push_back(8'($urandom_range(255)));
      return;
    end
    repeat ($urandom_range(2)) text_buf.push_back(blank_char());
    pick = $urandom_range(3);
    if (pick == 0) text_buf.push_back(CH_PLUS);
    else if (pick == 1) text_buf.push_back(CH_MINUS);
    // Integer digits, with extra weight around the saturation boundary.
    pick = $urandom_range(9);
    if (pick < 2) begin
    end else if (pick < 8) begin
      repeat ($urandom_range(1, 3)) text_buf.push_back(digit_char());
    end else if (pick == 8) begin
      text_buf.push_back(CH_ZERO + 8'd1);
      text_buf.push_back(CH_ZERO + 8'd2);
      text_buf.push_back(CH_ZERO + 8'($urandom_range(6, 9)));
    end else begin
      repeat ($urandom_range(4, 6)) text_buf.push_back(digit_char());
    end
    if ($urandom_range(2) != 0) begin
      text_buf.push_back(CH_POINT);
      n = ($urandom_range(4) == 0) ? $urandom_range(8, 12) : $urandom_range(3);
      repeat (n) text_buf.push_back(digit_char());
    end
    repeat ($urandom_range(2)) text_buf.push_back(blank_char());
    if (kind < 28) begin
      case ($urandom_range(3))
        0: junk = CH_POINT;
        1: junk = ($urandom_range(1) != 0) ? CH_PLUS : CH_MINUS;
        2: junk = digit_char();
        default: junk = 8'($urandom_range(255));
      endcase
      pos = $urandom_range(text_buf.size());
      text_buf.insert(pos, junk);
    end
    if (text_buf.size() == 0) text_buf.push_back(CH_POINT);
  endtask

  task automatic run_random(int unsigned upto);
    while (chars_sent < upto) begin
      build_text();
      send_text();
    end
    char_valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
  endtask

  initial begin
    int unsigned directed_chars;
    int unsigned share;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed corner cases.
    send_word(".");
    send_word("..");
    send_word("-");
    send_word(" ");
    send_word("-0");
    text_buf.delete();
    text_buf.push_back(8'h00);
    send_text();
    text_buf.delete();
    text_buf.push_back(CH_ZERO + 8'd7);
    text_buf.push_back(8'hFF);
    send_text();
    send_word("-128");
    send_word("999");
    send_word(".0000000019");
    directed_chars = chars_sent;
    share = (TOTAL_CHARS - directed_chars) / 3;

    // Sender idles lightly, receiver heavily.
    run_random(directed_chars + share);

    // The other way round.
    send_idle_pct = 46;
    recv_idle_pct = 11;
    run_random(directed_chars + 2 * share);

    // No idling, with a long receiver hold-off so the block backs up.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    holds_asked++;
    run_random(TOTAL_CHARS);

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (tracker.mismatch_count == 0 && tracker.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
